// File: sv/pvsc_pkg.sv
// ----------------------------------------------------------------------------
// pvsc_pkg
// Shared codes, widths and control bundles of the surplus charge controller.
// ----------------------------------------------------------------------------
package pvsc_pkg;

  // operating modes
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_OFF      = 2'd1;
  localparam logic [1:0] MODE_SURPLUS  = 2'd2;
  localparam logic [1:0] MODE_MIN_PV   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WATTS_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ON       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_GRID  = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // accepted grid reading window, watts
  localparam logic signed [17:0] GRID_LO = -18'sd100000;
  localparam logic signed [17:0] GRID_HI = 18'sd100000;

  // milliseconds per minute
  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  // divider: one quotient bit per step
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned DIV_CNT_W = 4;

  typedef struct packed {
    logic load;      // latch the accepted item, update the grid reading
    logic calc;      // average surplus, set up divider and hold product
    logic div_step;  // one restoring divide step
    logic decide;    // hysteresis, hold and clamp
    logic emit;      // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic need_div;  // active mode with a car: the divide path runs
  } sts_t;

endpackage

// File: sv/pvsc_if.sv
// ----------------------------------------------------------------------------
// pvsc_if
// Valid/ready channels for input ticks and result items.
// ----------------------------------------------------------------------------
interface pvsc_in_if;
  logic               valid;
  logic               ready;
  logic               grid_valid;
  logic signed [17:0] grid_reading;
  logic               car_connected;
  logic [15:0]        charger_power;
  logic [7:0]         present_current;
  logic [7:0]         box_min_current;
  logic [31:0]        now_ms;

  modport source (output valid, grid_valid, grid_reading, car_connected, charger_power,
                  present_current, box_min_current, now_ms, input ready);
  modport sink   (input valid, grid_valid, grid_reading, car_connected, charger_power,
                  present_current, box_min_current, now_ms, output ready);
endinterface

interface pvsc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         target_current;
  logic               change_request;
  logic signed [15:0] surplus_power;

  modport source (output valid, target_current, change_request, surplus_power,
                  input ready);
  modport sink   (input valid, target_current, change_request, surplus_power,
                  output ready);
endinterface

// File: sv/pvsc_ctrl.sv
// ----------------------------------------------------------------------------
// pvsc_ctrl
// Sequencer: accepts one tick, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module pvsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pvsc_pkg::sts_t  sts,
  output pvsc_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CALC   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [pvsc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == {pvsc_pkg::DIV_CNT_W{1'b1}}) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/pvsc_dp.sv
// ----------------------------------------------------------------------------
// pvsc_dp
// Datapath: configuration, state, surplus average, serial divider, decision.
// ----------------------------------------------------------------------------
module pvsc_dp #(
  parameter int CURRENT_MIN = 0,
  parameter int CURRENT_MAX = 160
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pvsc_pkg::cmd_t                     cmd,
  output pvsc_pkg::sts_t                     sts,
  input  logic                               cfg_we,
  input  logic [pvsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pvsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_grid_valid,
  input  logic signed [17:0]                 in_grid_reading,
  input  logic                               in_car_connected,
  input  logic [15:0]                        in_charger_power,
  input  logic [7:0]                         in_present_current,
  input  logic [7:0]                         in_box_min_current,
  input  logic [31:0]                        in_now_ms,
  output logic [7:0]                         out_target_current,
  output logic                               out_change_request,
  output logic signed [15:0]                 out_surplus_power
);

  localparam int unsigned W = pvsc_pkg::DIV_W;
  localparam logic [W-1:0] MIN_C = W'(CURRENT_MIN);
  localparam logic [W-1:0] MAX_C = W'(CURRENT_MAX);

  // configuration
  logic [1:0]         op_mode_r;
  logic signed [15:0] power_offset_r;
  logic [15:0]        wps_r;
  logic [7:0]         start_limit_r;
  logic [7:0]         stop_limit_r;
  logic [7:0]         min_on_r;
  logic               invert_r;

  // state
  logic signed [17:0] grid_power_r;
  logic signed [15:0] prev_surplus_r;
  logic [31:0]        act_time_r;

  // latched item
  logic               car_r;
  logic [15:0]        cpower_r;
  logic [7:0]         present_r;
  logic [7:0]         boxmin_r;
  logic [31:0]        now_r;

  // working registers
  logic [23:0]        hold_ms_r;
  logic               hold_r;
  logic               zero_tgt_r;
  logic [W-1:0]       rem_r;
  logic [W-1:0]       quo_r;
  logic [7:0]         res_tgt_r;
  logic               res_chg_r;
  logic signed [15:0] res_spl_r;

  // surplus average
  logic [15:0]        raw;
  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;
  logic signed [15:0] avg;

  // divide step
  logic [W:0]         shifted;
  logic [W:0]         diff;
  logic               q_bit;

  // decision
  logic [31:0]        elapsed;
  logic               hold_nxt;
  logic [W-1:0]       tgt;
  logic               below;
  logic [W-1:0]       t_hyst;
  logic [W-1:0]       t_lo;
  logic [W-1:0]       t_clamp;

  assign sts.need_div = op_mode_r[1] && car_r;

  assign raw     = cpower_r - grid_power_r[15:0] - power_offset_r;
  assign sum     = 17'(signed'(raw)) + 17'(prev_surplus_r);
  // round toward zero: bias every negative sum by one before halving
  assign sum_adj = sum + 17'(sum[16]);
  assign avg     = sum_adj[16:1];

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, wps_r};
  assign q_bit   = !diff[W];

  assign elapsed  = now_r - act_time_r;
  assign hold_nxt = (op_mode_r == pvsc_pkg::MODE_MIN_PV) ||
                    ((min_on_r != 8'd0) && (act_time_r != 32'd0) &&
                     (elapsed < {8'd0, hold_ms_r}));

  always_comb begin
    tgt     = zero_tgt_r ? '0 : quo_r;
    below   = (present_r == 8'd0) ? (tgt < W'(start_limit_r)) : (tgt < W'(stop_limit_r));
    t_hyst  = below ? (hold_r ? W'(boxmin_r) : '0) : tgt;
    t_lo    = (t_hyst < MIN_C) ? MIN_C : t_hyst;
    t_clamp = (t_lo > MAX_C) ? MAX_C : t_lo;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r      <= pvsc_pkg::MODE_OFF;
      power_offset_r <= '0;
      wps_r          <= 16'd69;
      start_limit_r  <= 8'd61;
      stop_limit_r   <= 8'd60;
      min_on_r       <= '0;
      invert_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pvsc_pkg::REG_OP_MODE:      op_mode_r      <= cfg_wdata[1:0];
        pvsc_pkg::REG_POWER_OFFSET: power_offset_r <= cfg_wdata;
        pvsc_pkg::REG_WATTS_STEP:   wps_r          <= cfg_wdata;
        pvsc_pkg::REG_START_LIMIT:  start_limit_r  <= cfg_wdata[7:0];
        pvsc_pkg::REG_STOP_LIMIT:   stop_limit_r   <= cfg_wdata[7:0];
        pvsc_pkg::REG_MIN_ON:       min_on_r       <= cfg_wdata[7:0];
        pvsc_pkg::REG_INVERT_GRID:  invert_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_power_r   <= '0;
      prev_surplus_r <= '0;
      act_time_r     <= '0;
    end else begin
      if (cmd.load && in_grid_valid &&
          (in_grid_reading >= pvsc_pkg::GRID_LO) && (in_grid_reading <= pvsc_pkg::GRID_HI)) begin
        grid_power_r <= invert_r ? -in_grid_reading : in_grid_reading;
      end
      if (cmd.calc) begin
        if (op_mode_r == pvsc_pkg::MODE_OFF || (op_mode_r[1] && !car_r)) begin
          prev_surplus_r <= '0;
        end else if (op_mode_r[1]) begin
          prev_surplus_r <= avg;
        end
      end
      if (cmd.decide && (present_r == 8'd0) && (t_clamp >= MIN_C)) begin
        act_time_r <= now_r;
      end
    end
  end

  // item, divider and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      car_r     <= in_car_connected;
      cpower_r  <= in_charger_power;
      present_r <= in_present_current;
      boxmin_r  <= in_box_min_current;
      now_r     <= in_now_ms;
    end
    if (cmd.calc) begin
      hold_ms_r  <= 24'(min_on_r) * 24'(pvsc_pkg::MS_PER_MIN);
      rem_r      <= '0;
      quo_r      <= avg;
      zero_tgt_r <= (avg <= 16'sd0) || (wps_r == 16'd0);
      if (!op_mode_r[1]) begin
        res_tgt_r <= present_r;
        res_chg_r <= 1'b0;
        res_spl_r <= '0;
      end else if (!car_r) begin
        res_tgt_r <= '0;
        res_chg_r <= (present_r != 8'd0);
        res_spl_r <= '0;
      end else begin
        res_spl_r <= avg;
      end
    end
    if (cmd.div_step) begin
      rem_r  <= q_bit ? diff[W-1:0] : shifted[W-1:0];
      quo_r  <= {quo_r[W-2:0], q_bit};
      hold_r <= hold_nxt;
    end
    if (cmd.decide) begin
      res_tgt_r <= t_clamp[7:0];
      res_chg_r <= (t_clamp != W'(present_r));
    end
    if (cmd.emit) begin
      out_target_current <= res_tgt_r;
      out_change_request <= res_chg_r;
      out_surplus_power  <= res_spl_r;
    end
  end

endmodule

// File: sv/pv_surplus_charge_current.sv
// Timing: with a car in an active mode a tick passes CALC, the serial divider (one
// quotient bit per cycle), DECIDE and EMIT; otherwise only CALC and EMIT.
// Ticks are taken one at a time, a new one only back in IDLE; a result held by
// the sink stalls the next tick in EMIT.
// Reset: synchronous, active low; configuration registers return to their defaults and the
// grid reading, surplus average and activation stamp clear to zero.
// ----------------------------------------------------------------------------
// pv_surplus_charge_current
// Surplus-driven charge current controller, one result per tick.
// ----------------------------------------------------------------------------
module pv_surplus_charge_current #(
  parameter int CURRENT_MIN = 0,
  parameter int CURRENT_MAX = 160
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pvsc_in_if.sink                         in_ch,
  pvsc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pvsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pvsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pvsc_pkg::cmd_t cmd;
  pvsc_pkg::sts_t sts;

  pvsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pvsc_dp #(
    .CURRENT_MIN (CURRENT_MIN),
    .CURRENT_MAX (CURRENT_MAX)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .in_grid_valid      (in_ch.grid_valid),
    .in_grid_reading    (in_ch.grid_reading),
    .in_car_connected   (in_ch.car_connected),
    .in_charger_power   (in_ch.charger_power),
    .in_present_current (in_ch.present_current),
    .in_box_min_current (in_ch.box_min_current),
    .in_now_ms          (in_ch.now_ms),
    .out_target_current (out_ch.target_current),
    .out_change_request (out_ch.change_request),
    .out_surplus_power  (out_ch.surplus_power)
  );

endmodule

// File: sv/pvsc_checker.sv
// ----------------------------------------------------------------------------
// pvsc_checker
// Port-level checks of the surplus charge controller, bound to the top level.
// ----------------------------------------------------------------------------
module pvsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_target_current,
  input logic        out_change_request,
  input logic [15:0] out_surplus_power
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // a pending result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_target_current) && $stable(out_change_request) &&
      $stable(out_surplus_power))
    else $error("result payload changed while stalled");

  // one tick at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while a tick is in progress");

  // no result in the cycle after a transfer in
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pv_surplus_charge_current pvsc_checker u_pvsc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_target_current (out_ch.target_current),
  .out_change_request (out_ch.change_request),
  .out_surplus_power  (out_ch.surplus_power)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the surplus charge current controller. A short
// table of directed ticks and register writes covers modes, grid window
// edges, hysteresis, the minimum-current hold and the clamp. Randomized
// charging sessions under changing register settings follow. Each result is
// checked against the table's value where given, else a cycle-free model.
// ----------------------------------------------------------------------------
module tb;

  localparam int CUR_MIN     = 0;
  localparam int CUR_MAX     = 160;
  localparam int STALL_LIMIT = 1000;
  localparam int N_PHASES    = 11;
  localparam int PHASE_TICKS = 150;
  localparam int DRAIN_TAIL  = 40;

  typedef struct packed {
    logic               grid_valid;
    logic signed [17:0] grid_reading;
    logic               car_connected;
    logic [15:0]        charger_power;
    logic [7:0]         present_current;
    logic [7:0]         box_min_current;
    logic [31:0]        now_ms;
  } tick_t;

  typedef struct packed {
    logic [7:0]         target_current;
    logic               change_request;
    logic signed [15:0] surplus_power;
  } charge_t;

  typedef struct {
    bit                             is_cfg;
    logic [pvsc_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                    val;
    tick_t                          tick;
    bit                             known;
    charge_t                        want;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [pvsc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [pvsc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pvsc_in_if  in_ch ();
  pvsc_out_if out_ch ();

  pv_surplus_charge_current u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register mirror
  logic [1:0]         m_mode;
  logic signed [15:0] m_offset;
  logic [15:0]        m_wps;
  logic [7:0]         m_start;
  logic [7:0]         m_stop;
  logic [7:0]         m_min_on;
  logic               m_invert;

  // controller state
  logic signed [17:0] grid_pwr;
  logic signed [15:0] avg_surplus;
  logic [31:0]        act_stamp;

  charge_t expected_charge[$];
  row_t    dir_rows[$];

  // session shaping for the random part
  logic [31:0] sim_ms;
  bit          car_on;
  logic [7:0]  last_target;
  bit          no_idle;

  int n_ticks;
  int n_results;
  int n_errors;
  int n_settings;
  int idle_cycles;

  function automatic charge_t predict_charge(input tick_t t);
    charge_t            r;
    int                 cpw;
    int                 gp;
    int                 off;
    int                 raw;
    int                 s;
    int                 wps_i;
    int                 tgt;
    logic signed [15:0] s16;
    logic [31:0]        elapsed;
    logic [31:0]        win;
    bit                 hold;
    r = '0;
    s = 0;
    if (t.grid_valid && t.grid_reading >= -100000 && t.grid_reading <= 100000)
      grid_pwr = m_invert ? -t.grid_reading : t.grid_reading;
    if (m_mode == pvsc_pkg::MODE_DISABLED || m_mode == pvsc_pkg::MODE_OFF) begin
      if (m_mode == pvsc_pkg::MODE_OFF) avg_surplus = '0;
      r.target_current = t.present_current;
      return r;
    end
    if (t.car_connected) begin
      cpw = int'(t.charger_power);
      gp  = int'(grid_pwr);
      off = int'(m_offset);
      raw = cpw - gp - off;
      s16 = raw[15:0];
      s   = int'(s16);
      s   = (int'(avg_surplus) + s) / 2;
      avg_surplus = s[15:0];
      wps_i = int'(m_wps);
      tgt = 0;
      if (s > 0 && wps_i != 0) tgt = s / wps_i;
      if ((t.present_current == 0 && tgt < int'(m_start)) ||
          (t.present_current != 0 && tgt < int'(m_stop))) begin
        elapsed = t.now_ms - act_stamp;
        win     = 32'(m_min_on) * 32'd60000;
        hold = (m_mode == pvsc_pkg::MODE_MIN_PV) ||
               (m_min_on != 0 && act_stamp != 0 && elapsed < win);
        tgt = hold ? int'(t.box_min_current) : 0;
      end
      if (tgt < CUR_MIN) tgt = CUR_MIN;
      if (tgt > CUR_MAX) tgt = CUR_MAX;
      // a stamp of zero reads as never activated
      if (t.present_current == 0 && tgt >= CUR_MIN) act_stamp = t.now_ms;
    end else begin
      tgt = 0;
      avg_surplus = '0;
    end
    r.target_current = tgt[7:0];
    r.change_request = (tgt != int'(t.present_current));
    r.surplus_power  = s[15:0];
    return r;
  endfunction

  function automatic void add_cfg(input logic [pvsc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] val);
    row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_tick(input bit gv, input int rd, input bit car, input int cp,
                                   input int pc, input int bm, input logic [31:0] now,
                                   input bit known = 1'b0, input int e_tgt = 0,
                                   input bit e_chg = 1'b0, input int e_sur = 0);
    row_t row;
    row = '{default: '0};
    row.tick.grid_valid      = gv;
    row.tick.grid_reading    = rd[17:0];
    row.tick.car_connected   = car;
    row.tick.charger_power   = cp[15:0];
    row.tick.present_current = pc[7:0];
    row.tick.box_min_current = bm[7:0];
    row.tick.now_ms          = now;
    row.known                = known;
    row.want.target_current  = e_tgt[7:0];
    row.want.change_request  = e_chg;
    row.want.surplus_power   = e_sur[15:0];
    dir_rows.push_back(row);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    r;
    int    grid;
    int    steps;
    int    jitter;
    r = $urandom_range(0, 99);
    sim_ms = sim_ms + $urandom_range(200, 15000);
    if ($urandom_range(0, 49) == 0) sim_ms = sim_ms + $urandom();
    if ($urandom_range(0, 29) == 0) car_on = !car_on;
    t.now_ms          = sim_ms;
    t.box_min_current = 8'($urandom_range(0, 160));
    t.charger_power   = 16'((r < 50) ? $urandom_range(0, 11000) : $urandom_range(0, 65535));
    if (r < 10) begin
      // noise: random grid validity and reading, car flag, present current and time
      t.grid_valid      = 1'($urandom_range(0, 1));
      t.grid_reading    = 18'($urandom());
      t.car_connected   = 1'($urandom_range(0, 1));
      t.present_current = 8'($urandom_range(0, 160));
      t.now_ms          = $urandom();
    end else begin
      // aim the surplus at 0 to 200 steps, spanning the thresholds, with 200 W of jitter either way
      steps  = $urandom_range(0, 200);
      jitter = $urandom_range(0, 400);
      grid   = int'(t.charger_power) - int'(m_offset) - steps * int'(m_wps) + jitter - 200;
      if (m_invert) grid = -grid;
      if (grid > 131071) grid = 131071;
      if (grid < -131072) grid = -131072;
      t.grid_valid      = ($urandom_range(0, 9) != 0);
      t.grid_reading    = grid[17:0];
      t.car_connected   = car_on;
      t.present_current = ($urandom_range(0, 9) < 7) ? last_target
                                                      : 8'($urandom_range(0, 160));
    end
    return t;
  endfunction

  // all calls start and end on a rising edge
  task automatic write_reg(input logic [pvsc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pvsc_pkg::REG_OP_MODE:      m_mode   = val[1:0];
      pvsc_pkg::REG_POWER_OFFSET: m_offset = val;
      pvsc_pkg::REG_WATTS_STEP:   m_wps    = val;
      pvsc_pkg::REG_START_LIMIT:  m_start  = val[7:0];
      pvsc_pkg::REG_STOP_LIMIT:   m_stop   = val[7:0];
      pvsc_pkg::REG_MIN_ON:       m_min_on = val[7:0];
      pvsc_pkg::REG_INVERT_GRID:  m_invert = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold the sender until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_charge.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(input tick_t t, input bit known, input charge_t want);
    int      gap;
    charge_t r;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.grid_valid      <= t.grid_valid;
    in_ch.grid_reading    <= t.grid_reading;
    in_ch.car_connected   <= t.car_connected;
    in_ch.charger_power   <= t.charger_power;
    in_ch.present_current <= t.present_current;
    in_ch.box_min_current <= t.box_min_current;
    in_ch.now_ms          <= t.now_ms;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_charge(t);
    expected_charge.push_back(known ? want : r);
    last_target = r.target_current;
    n_ticks++;
  endtask

  task automatic program_phase(input int p);
    logic [1:0]  md;
    logic [15:0] off;
    logic [15:0] wps;
    logic [7:0]  st;
    logic [7:0]  sp;
    logic [7:0]  mo;
    logic        inv;
    int          r;
    if (p == 0) begin
      md = pvsc_pkg::MODE_MIN_PV; off = 16'h8000; wps = 16'h0000;
      st = 8'd0; sp = 8'd0; mo = 8'd0; inv = 1'b0;
    end else if (p == 1) begin
      md = pvsc_pkg::MODE_SURPLUS; off = 16'h7FFF; wps = 16'hFFFF;
      st = 8'd160; sp = 8'd160; mo = 8'd255; inv = 1'b1;
    end else begin
      r = $urandom_range(0, 9);
      md  = (r == 0) ? pvsc_pkg::MODE_DISABLED : (r == 1) ? pvsc_pkg::MODE_OFF :
            (r < 6) ? pvsc_pkg::MODE_SURPLUS : pvsc_pkg::MODE_MIN_PV;
      off = 16'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4000) - 2000);
      wps = 16'(($urandom_range(0, 4) != 0) ? $urandom_range(30, 300)
                                             : $urandom_range(0, 65535));
      st  = 8'($urandom_range(0, 160));
      sp  = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, st) : $urandom_range(0, 160));
      r   = $urandom_range(0, 9);
      mo  = (r < 3) ? 8'd0 : (r < 8) ? 8'($urandom_range(1, 5)) : 8'($urandom_range(0, 255));
      inv = 1'($urandom_range(0, 1));
    end
    settle();
    write_reg(pvsc_pkg::REG_OP_MODE, {14'd0, md});
    write_reg(pvsc_pkg::REG_POWER_OFFSET, off);
    write_reg(pvsc_pkg::REG_WATTS_STEP, wps);
    write_reg(pvsc_pkg::REG_START_LIMIT, {8'd0, st});
    write_reg(pvsc_pkg::REG_STOP_LIMIT, {8'd0, sp});
    write_reg(pvsc_pkg::REG_MIN_ON, {8'd0, mo});
    write_reg(pvsc_pkg::REG_INVERT_GRID, {15'd0, inv});
    n_settings++;
  endtask

  // result side
  initial begin
    int      stall;
    charge_t e;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_results++;
      if (expected_charge.size() == 0) begin
        $error("result with no tick outstanding: target_current %0d", out_ch.target_current);
        n_errors++;
      end else begin
        e = expected_charge.pop_front();
        if (out_ch.target_current !== e.target_current) begin
          $error("target_current: expected %0d, got %0d",
                 e.target_current, out_ch.target_current);
          n_errors++;
        end
        if (out_ch.change_request !== e.change_request) begin
          $error("change_request: expected %0d, got %0d",
                 e.change_request, out_ch.change_request);
          n_errors++;
        end
        if (out_ch.surplus_power !== e.surplus_power) begin
          $error("surplus_power: expected %0d, got %0d",
                 e.surplus_power, out_ch.surplus_power);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    charge_t none;
    tick_t   t;
    none = '0;
    idle_cycles = 0;
    n_ticks = 0; n_results = 0; n_errors = 0; n_settings = 1;
    m_mode = pvsc_pkg::MODE_OFF; m_offset = '0; m_wps = 16'd69;
    m_start = 8'd61; m_stop = 8'd60; m_min_on = 8'd0; m_invert = 1'b0;
    grid_pwr = '0; avg_surplus = '0; act_stamp = '0;
    sim_ms = 32'd1000; car_on = 1'b1; last_target = '0; no_idle = 1'b0;

    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.grid_valid      <= 1'b0;
    in_ch.grid_reading    <= '0;
    in_ch.car_connected   <= 1'b0;
    in_ch.charger_power   <= '0;
    in_ch.present_current <= '0;
    in_ch.box_min_current <= '0;
    in_ch.now_ms          <= '0;

    // mode off after reset, then disabled: present current passes through
    add_tick(1, 5000, 1, 3000, 42, 60, 1000, 1, 42, 0, 0);
    add_cfg(pvsc_pkg::REG_OP_MODE, 16'(pvsc_pkg::MODE_DISABLED));
    add_tick(0, 0, 1, 65535, 160, 0, 2000, 1, 160, 0, 0);
    add_cfg(pvsc_pkg::REG_OP_MODE, 16'(pvsc_pkg::MODE_SURPLUS));
    // no car, then a car with no charger power
    add_tick(0, 0, 0, 1234, 0, 0, 2500, 1, 0, 0, 0);
    add_tick(0, 0, 0, 1234, 160, 0, 2600, 1, 0, 1, 0);
    add_tick(1, 0, 1, 0, 0, 80, 3000, 1, 0, 0, 0);
    // grid window edges, readings outside it and an invalid reading
    add_tick(1, -100000, 1, 65535, 0, 80, 4000);
    add_tick(1, 100000, 1, 0, 20, 80, 5000);
    add_tick(1, -100001, 1, 8000, 70, 80, 6000);
    add_tick(1, 100001, 1, 9000, 70, 80, 6500);
    add_tick(1, 131071, 1, 9000, 70, 80, 7000);
    add_tick(1, -131072, 1, 9000, 0, 80, 8000);
    add_tick(0, 50000, 1, 9000, 65, 80, 9000);
    // inverted grid, most negative offset, clamp at the top
    add_cfg(pvsc_pkg::REG_WATTS_STEP, 16'd1);
    add_cfg(pvsc_pkg::REG_POWER_OFFSET, 16'h8000);
    add_cfg(pvsc_pkg::REG_INVERT_GRID, 16'd1);
    add_tick(1, 1000, 1, 30000, 0, 80, 10000);
    add_tick(1, -30000, 1, 100, 10, 80, 11000);
    // zero watts per step: no target
    add_cfg(pvsc_pkg::REG_WATTS_STEP, 16'd0);
    add_tick(1, 0, 1, 20000, 50, 90, 12000);
    // minimum plus surplus always holds the box minimum
    add_cfg(pvsc_pkg::REG_OP_MODE, 16'(pvsc_pkg::MODE_MIN_PV));
    add_cfg(pvsc_pkg::REG_WATTS_STEP, 16'd1);
    add_cfg(pvsc_pkg::REG_START_LIMIT, 16'd160);
    add_cfg(pvsc_pkg::REG_STOP_LIMIT, 16'd160);
    add_cfg(pvsc_pkg::REG_MIN_ON, 16'd255);
    add_cfg(pvsc_pkg::REG_POWER_OFFSET, 16'h7FFF);
    add_cfg(pvsc_pkg::REG_INVERT_GRID, 16'd0);
    add_tick(1, 0, 1, 0, 0, 100, 0);
    add_tick(0, 0, 1, 5000, 100, 160, 5000);
    // minimum on-time: stamp at zero, stamp across the wrap, window edge
    add_cfg(pvsc_pkg::REG_OP_MODE, 16'(pvsc_pkg::MODE_SURPLUS));
    add_cfg(pvsc_pkg::REG_MIN_ON, 16'd1);
    add_cfg(pvsc_pkg::REG_START_LIMIT, 16'd0);
    add_cfg(pvsc_pkg::REG_POWER_OFFSET, 16'd0);
    add_cfg(pvsc_pkg::REG_WATTS_STEP, 16'd69);
    add_tick(1, 0, 1, 500, 0, 40, 32'h0000_0000);
    add_tick(1, 0, 1, 500, 30, 40, 32'h0000_000A);
    add_tick(1, 0, 1, 500, 0, 40, 32'hFFFF_FF00);
    add_tick(1, 0, 1, 500, 30, 40, 32'h0000_0100);
    add_tick(1, 0, 1, 500, 30, 45, 32'h0000_E95F);
    add_tick(1, 0, 1, 500, 30, 45, 32'h0000_E960);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
        n_settings++;
      end else begin
        no_idle = ($urandom_range(0, 3) == 0);
        send_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      no_idle = 1'b0;
      program_phase(p);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        t = rand_tick();
        send_tick(t, 1'b0, none);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_charge.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Covered %0d ticks under %0d register settings, %0d results checked.",
             n_ticks, n_settings, n_results);
    $display("Sessions mixed grid window edges, hysteresis, minimum-current holds and clamps.");
    if (n_errors == 0 && expected_charge.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
